[rtl/core/ccmt_pkg.sv]
// ----------------------------------------------------------------------------
// ccmt_pkg : shared types and constants for the crack contour merge and trace
// Command codes, move codes, trace phases and the command and status words
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ccmt_pkg;

   // field widths
   localparam int IdxW         = 16;
   localparam int GeoW         = 17;
   localparam int IdxSpan      = 1 << IdxW;
   localparam int MaxPixelsDef = 65536;

   // register reset values
   localparam logic [GeoW-1:0] GridWidthRst  = 17'd256;
   localparam logic [GeoW-1:0] GridHeightRst = 17'd256;

   // register indexes on the csr port
   localparam logic CsrGridWidth  = 1'b0;
   localparam logic CsrGridHeight = 1'b1;

   typedef enum logic [1:0] {
      CMD_BEGIN = 2'd0,
      CMD_MOVE  = 2'd1,
      CMD_STEP  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MV_UP    = 2'd0,
      MV_RIGHT = 2'd1,
      MV_DOWN  = 2'd2,
      MV_LEFT  = 2'd3
   } move_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_WALK   = 2'd1,
      PH_CLOSED = 2'd2
   } phase_type;

   // pixels a contour move marks
   typedef enum logic [1:0] {
      MK_NONE = 2'd0,
      MK_SAME = 2'd1,
      MK_TURN = 2'd2
   } mark_kind_type;

   // neighbour offset as row and column steps
   typedef struct packed {
      logic row_dec;
      logic row_inc;
      logic col_dec;
      logic col_inc;
   } dir_type;

   // controller to datapath
   typedef struct packed {
      logic latch;
      logic begin_do;
      logic move_first;
      logic mark;
      logic mark_prev_dir;
      logic set_prev;
      logic clear_start;
      logic clear_step;
      logic trace_init;
      logic div_start;
      logic read_p;
      logic read_s;
      logic decide;
      logic rsp_first;
      logic rsp_closed;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type       cmd;
      logic          load_pending;
      mark_kind_type mark_kind;
      phase_type     phase;
      logic          geom_dirty;
      logic          div_done;
      logic          clear_last;
   } dp_status_type;

   // pixel that must be set to keep going straight
   function automatic dir_type prim_dir(input move_type m);
      dir_type d;
      d = '0;
      case (m)
         MV_RIGHT: d.col_inc = 1'b1;
         MV_DOWN:  d.row_inc = 1'b1;
         MV_LEFT:  d.col_dec = 1'b1;
         default:  d.row_dec = 1'b1;
      endcase
      return d;
   endfunction

   // diagonal pixel that makes the walk turn outwards
   function automatic dir_type sec_dir(input move_type m);
      dir_type d;
      d = '0;
      case (m)
         MV_RIGHT: begin
            d.row_dec = 1'b1;
            d.col_inc = 1'b1;
         end
         MV_DOWN: begin
            d.row_inc = 1'b1;
            d.col_inc = 1'b1;
         end
         MV_LEFT: begin
            d.row_inc = 1'b1;
            d.col_dec = 1'b1;
         end
         default: begin
            d.row_dec = 1'b1;
            d.col_dec = 1'b1;
         end
      endcase
      return d;
   endfunction

endpackage

[rtl/core/ccmt_div.sv]
// ----------------------------------------------------------------------------
// ccmt_div : radix-2 restoring divider
// Splits a pixel index into row and column, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ccmt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ccmt_pkg::IdxW-1:0]     dividend,
   input  logic [ccmt_pkg::GeoW-1:0]     divisor,
   output logic [ccmt_pkg::IdxW-1:0]     quotient,
   output logic [ccmt_pkg::IdxW-1:0]     remainder,
   output logic                          done
);
   import ccmt_pkg::*;

   localparam int CntW = $clog2(IdxW);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [GeoW-1:0] rem_ff, rem_in;
   logic [IdxW-1:0] quo_ff, quo_in;
   logic [GeoW:0]   trial;
   logic [GeoW:0]   dvs_ext;

   // one shift and trial subtract per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[IdxW-1]};
      dvs_ext = {1'b0, divisor};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         if (trial >= dvs_ext) begin
            rem_in = GeoW'(trial - dvs_ext);
            quo_in = {quo_ff[IdxW-2:0], 1'b1};
         end else begin
            rem_in = trial[GeoW-1:0];
            quo_in = {quo_ff[IdxW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(IdxW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // partial remainder and quotient
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff[IdxW-1:0];
   assign done      = done_ff;

endmodule

[rtl/core/ccmt_datapath.sv]
// ----------------------------------------------------------------------------
// ccmt_datapath : border bitmap, merge registers and trace walker
// Holds the grid registers, the one-port border bitmap, the load and trace
// pointers and the result word; acts on controller commands and csr writes.
// ----------------------------------------------------------------------------
module ccmt_datapath #(
   parameter int MAX_PIXELS = ccmt_pkg::MaxPixelsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ccmt_pkg::GeoW-1:0]     csr_wdata,
   input  logic [1:0]                    req_cmd,
   input  logic [ccmt_pkg::IdxW-1:0]     req_start_index,
   input  logic [1:0]                    req_move_code,
   input  ccmt_pkg::dp_cmd_type          dp_cmd,
   output ccmt_pkg::dp_status_type       dp_status,
   output logic [1:0]                    rsp_out_move,
   output logic                          rsp_move_valid,
   output logic                          rsp_trace_done
);
   import ccmt_pkg::*;

   localparam int MapDepth = (MAX_PIXELS < IdxSpan) ? MAX_PIXELS : IdxSpan;
   localparam int AddrW    = $clog2(MapDepth);
   localparam int NbW      = GeoW + 1;

   typedef struct packed {
      logic           ok;
      logic [NbW-1:0] addr;
   } nb_type;

   // grid registers
   logic [GeoW-1:0] grid_width_ff, grid_width_in;
   logic [GeoW-1:0] grid_height_ff, grid_height_in;
   logic            geom_dirty_ff, geom_dirty_in;
   logic [GeoW-1:0] w_eff, h_eff;

   // latched request word
   cmd_type         cmd_ff, cmd_in;
   logic [IdxW-1:0] start_idx_ff, start_idx_in;
   move_type        move_ff, move_in;

   // merge and load state
   logic [IdxW-1:0] merged_ff, merged_in;
   logic [IdxW-1:0] load_index_ff, load_index_in;
   move_type        load_prev_ff, load_prev_in;
   logic            load_pending_ff, load_pending_in;

   // trace state
   logic [IdxW-1:0] trace_index_ff, trace_index_in;
   move_type        trace_prev_ff, trace_prev_in;
   phase_type       phase_ff, phase_in;
   logic [IdxW-1:0] row_ff, row_in;
   logic [IdxW-1:0] col_ff, col_in;
   logic            p_ok_ff, p_ok_in;
   logic            s_ok_ff, s_ok_in;
   logic            p_bit_ff, p_bit_in;
   logic [NbW-1:0]  p_addr_ff, p_addr_in;
   logic [NbW-1:0]  s_addr_ff, s_addr_in;

   // clearing sweep
   logic [AddrW-1:0] clear_cnt_ff, clear_cnt_in;

   // result word
   move_type        rsp_move_ff, rsp_move_in;
   logic            rsp_mv_valid_ff, rsp_mv_valid_in;
   logic            rsp_done_ff, rsp_done_in;

   // bitmap port
   logic             map_mem [MapDepth];
   logic             map_rd_ff;
   logic             map_we, map_re, map_wdata;
   logic [AddrW-1:0] map_addr;

   // helpers
   move_type        mark_dir;
   logic [IdxW-1:0] mark_idx;
   logic            mark_ok, begin_ok;
   dir_type         nb_sel;
   nb_type          nb;
   logic            s_bit, dec_go, dec_closed;
   move_type        dec_move;
   dir_type         dec_dir;
   logic [NbW-1:0]  dec_addr;
   mark_kind_type   mark_kind;
   logic            div_go, div_done;
   logic [IdxW-1:0] div_dividend, div_quot, div_rem;

   // neighbour address and whether it can hold a set pixel
   function automatic nb_type nb_calc(input dir_type d, input logic [IdxW-1:0] idx,
                                      input logic [IdxW-1:0] row, input logic [IdxW-1:0] col,
                                      input logic [GeoW-1:0] w, input logic [GeoW-1:0] h);
      nb_type         r;
      logic           on_grid;
      logic [NbW-1:0] a;
      on_grid = 1'b1;
      if (d.row_dec && (row == '0)) on_grid = 1'b0;
      if (d.row_inc && ((GeoW'(row) + GeoW'(1)) >= h)) on_grid = 1'b0;
      if (d.col_dec && (col == '0)) on_grid = 1'b0;
      if (d.col_inc && ((GeoW'(col) + GeoW'(1)) >= w)) on_grid = 1'b0;
      a = NbW'(idx);
      if (d.row_inc) a = a + NbW'(w);
      if (d.row_dec) a = a - NbW'(w);
      if (d.col_inc) a = a + NbW'(1);
      if (d.col_dec) a = a - NbW'(1);
      r.ok   = on_grid && (a < NbW'(MapDepth));
      r.addr = a;
      return r;
   endfunction

   // one pixel step of the load pointer, wrapping on the index width
   function automatic logic [IdxW-1:0] step_idx(input move_type d, input logic [IdxW-1:0] idx,
                                                input logic [IdxW-1:0] w16);
      logic [IdxW-1:0] r;
      case (d)
         MV_UP:    r = idx - w16;
         MV_DOWN:  r = idx + w16;
         MV_RIGHT: r = idx + IdxW'(1);
         default:  r = idx - IdxW'(1);
      endcase
      return r;
   endfunction

   // zero width or height counts as one
   assign w_eff = (grid_width_ff == '0) ? GeoW'(1) : grid_width_ff;
   assign h_eff = (grid_height_ff == '0) ? GeoW'(1) : grid_height_ff;

   // row and column of the trace pixel
   assign div_go       = dp_cmd.trace_init | dp_cmd.div_start;
   assign div_dividend = dp_cmd.trace_init ? merged_ff : trace_index_ff;

   ccmt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (div_dividend),
      .divisor   (w_eff),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   // classify a move against the previous one
   always_comb begin
      if (move_ff == load_prev_ff) begin
         mark_kind = MK_SAME;
      end else if (load_prev_ff == move_type'(2'(move_ff + 2'd1))) begin
         mark_kind = MK_TURN;
      end else begin
         mark_kind = MK_NONE;
      end
   end

   // load pointer marking
   assign mark_dir = dp_cmd.mark_prev_dir ? load_prev_ff : move_ff;
   assign mark_idx = step_idx(mark_dir, load_index_ff, w_eff[IdxW-1:0]);
   assign mark_ok  = GeoW'(mark_idx) < GeoW'(MapDepth);
   assign begin_ok = GeoW'(start_idx_ff) < GeoW'(MapDepth);

   // neighbour lookup for the two reads of a step
   assign nb_sel = dp_cmd.read_s ? sec_dir(trace_prev_ff) : prim_dir(trace_prev_ff);
   assign nb     = nb_calc(nb_sel, trace_index_ff, row_ff, col_ff, w_eff, h_eff);

   // walk decision from the two neighbour bits
   always_comb begin
      s_bit      = s_ok_ff & map_rd_ff;
      dec_go     = 1'b0;
      dec_dir    = '0;
      dec_addr   = p_addr_ff;
      dec_closed = 1'b0;
      if (p_bit_ff && s_bit) begin
         dec_move = move_type'(2'(trace_prev_ff - 2'd1));
         dec_dir  = sec_dir(trace_prev_ff);
         dec_addr = s_addr_ff;
         dec_go   = 1'b1;
      end else if (p_bit_ff) begin
         dec_move = trace_prev_ff;
         dec_dir  = prim_dir(trace_prev_ff);
         dec_go   = 1'b1;
      end else begin
         dec_move   = move_type'(2'(trace_prev_ff + 2'd1));
         dec_closed = (trace_prev_ff == MV_UP) && (trace_index_ff == merged_ff);
      end
   end

   // bitmap port sharing
   always_comb begin
      map_we    = 1'b0;
      map_re    = 1'b0;
      map_wdata = 1'b1;
      map_addr  = nb.addr[AddrW-1:0];
      if (dp_cmd.clear_step) begin
         map_we    = 1'b1;
         map_wdata = 1'b0;
         map_addr  = clear_cnt_ff;
      end else if (dp_cmd.begin_do) begin
         map_we   = begin_ok;
         map_addr = start_idx_ff[AddrW-1:0];
      end else if (dp_cmd.mark) begin
         map_we   = mark_ok;
         map_addr = mark_idx[AddrW-1:0];
      end else if (dp_cmd.read_p || dp_cmd.read_s) begin
         map_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_addr] <= map_wdata;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[map_addr];
      end
   end

   // next state of registers and pointers
   always_comb begin
      grid_width_in   = grid_width_ff;
      grid_height_in  = grid_height_ff;
      geom_dirty_in   = geom_dirty_ff;
      merged_in       = merged_ff;
      load_index_in   = load_index_ff;
      load_prev_in    = load_prev_ff;
      load_pending_in = load_pending_ff;
      trace_index_in  = trace_index_ff;
      trace_prev_in   = trace_prev_ff;
      phase_in        = phase_ff;
      clear_cnt_in    = clear_cnt_ff;

      if (div_go) begin
         geom_dirty_in = 1'b0;
      end
      if (csr_we) begin
         if (csr_index == CsrGridWidth) begin
            grid_width_in = csr_wdata;
            geom_dirty_in = 1'b1;
         end else begin
            grid_height_in = csr_wdata;
         end
      end
      if (dp_cmd.begin_do) begin
         if (start_idx_ff < merged_ff) merged_in = start_idx_ff;
         load_index_in   = start_idx_ff;
         load_pending_in = 1'b1;
         phase_in        = PH_IDLE;
      end
      if (dp_cmd.move_first) begin
         load_prev_in    = move_ff;
         load_pending_in = 1'b0;
         phase_in        = PH_IDLE;
      end
      if (dp_cmd.mark) begin
         load_index_in = mark_idx;
      end
      if (dp_cmd.set_prev) begin
         load_prev_in = move_ff;
         phase_in     = PH_IDLE;
      end
      if (dp_cmd.clear_start) begin
         merged_in       = '1;
         load_pending_in = 1'b0;
         phase_in        = PH_IDLE;
         clear_cnt_in    = '0;
      end
      if (dp_cmd.clear_step) begin
         clear_cnt_in = clear_cnt_ff + AddrW'(1);
      end
      if (dp_cmd.trace_init) begin
         trace_index_in = merged_ff;
         trace_prev_in  = MV_RIGHT;
         phase_in       = PH_WALK;
      end
      if (dp_cmd.decide) begin
         if (dec_closed) begin
            phase_in = PH_CLOSED;
         end else begin
            trace_prev_in = dec_move;
            if (dec_go) trace_index_in = dec_addr[IdxW-1:0];
         end
      end
   end

   // next value of the payload registers
   always_comb begin
      cmd_in          = cmd_ff;
      start_idx_in    = start_idx_ff;
      move_in         = move_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      p_ok_in         = p_ok_ff;
      s_ok_in         = s_ok_ff;
      p_bit_in        = p_bit_ff;
      p_addr_in       = p_addr_ff;
      s_addr_in       = s_addr_ff;
      rsp_move_in     = rsp_move_ff;
      rsp_mv_valid_in = rsp_mv_valid_ff;
      rsp_done_in     = rsp_done_ff;

      if (dp_cmd.latch) begin
         cmd_in       = cmd_type'(req_cmd);
         start_idx_in = req_start_index;
         move_in      = move_type'(req_move_code);
      end
      if (div_done) begin
         row_in = div_quot;
         col_in = div_rem;
      end
      if (dp_cmd.read_p) begin
         p_ok_in   = nb.ok;
         p_addr_in = nb.addr;
      end
      if (dp_cmd.read_s) begin
         s_ok_in   = nb.ok;
         s_addr_in = nb.addr;
         p_bit_in  = p_ok_ff & map_rd_ff;
      end
      if (dp_cmd.decide && dec_go) begin
         if (dec_dir.row_inc) row_in = row_ff + IdxW'(1);
         if (dec_dir.row_dec) row_in = row_ff - IdxW'(1);
         if (dec_dir.col_inc) col_in = col_ff + IdxW'(1);
         if (dec_dir.col_dec) col_in = col_ff - IdxW'(1);
      end
      if (dp_cmd.rsp_first) begin
         rsp_move_in     = MV_RIGHT;
         rsp_mv_valid_in = 1'b1;
         rsp_done_in     = 1'b0;
      end
      if (dp_cmd.rsp_closed || (dp_cmd.decide && dec_closed)) begin
         rsp_move_in     = MV_UP;
         rsp_mv_valid_in = 1'b0;
         rsp_done_in     = 1'b1;
      end else if (dp_cmd.decide) begin
         rsp_move_in     = dec_move;
         rsp_mv_valid_in = 1'b1;
         rsp_done_in     = 1'b0;
      end
   end

   // state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff   <= GridWidthRst;
         grid_height_ff  <= GridHeightRst;
         geom_dirty_ff   <= 1'b0;
         merged_ff       <= '1;
         load_index_ff   <= '0;
         load_prev_ff    <= MV_UP;
         load_pending_ff <= 1'b0;
         trace_index_ff  <= '0;
         trace_prev_ff   <= MV_RIGHT;
         phase_ff        <= PH_IDLE;
         clear_cnt_ff    <= '0;
      end else begin
         grid_width_ff   <= grid_width_in;
         grid_height_ff  <= grid_height_in;
         geom_dirty_ff   <= geom_dirty_in;
         merged_ff       <= merged_in;
         load_index_ff   <= load_index_in;
         load_prev_ff    <= load_prev_in;
         load_pending_ff <= load_pending_in;
         trace_index_ff  <= trace_index_in;
         trace_prev_ff   <= trace_prev_in;
         phase_ff        <= phase_in;
         clear_cnt_ff    <= clear_cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      start_idx_ff    <= start_idx_in;
      move_ff         <= move_in;
      row_ff          <= row_in;
      col_ff          <= col_in;
      p_ok_ff         <= p_ok_in;
      s_ok_ff         <= s_ok_in;
      p_bit_ff        <= p_bit_in;
      p_addr_ff       <= p_addr_in;
      s_addr_ff       <= s_addr_in;
      rsp_move_ff     <= rsp_move_in;
      rsp_mv_valid_ff <= rsp_mv_valid_in;
      rsp_done_ff     <= rsp_done_in;
   end

   // status to the controller
   always_comb begin
      dp_status.cmd          = cmd_ff;
      dp_status.load_pending = load_pending_ff;
      dp_status.mark_kind    = mark_kind;
      dp_status.phase        = phase_ff;
      dp_status.geom_dirty   = geom_dirty_ff;
      dp_status.div_done     = div_done;
      dp_status.clear_last   = (clear_cnt_ff == AddrW'(MapDepth - 1));
   end

   assign rsp_out_move   = rsp_move_ff;
   assign rsp_move_valid = rsp_mv_valid_ff;
   assign rsp_trace_done = rsp_done_ff;

endmodule

[rtl/core/ccmt_ctrl.sv]
// ----------------------------------------------------------------------------
// ccmt_ctrl : sequencing controller
// Takes a word, walks it through marking, clearing or trace steps and
// raises the result strobe after a trace step.
// ----------------------------------------------------------------------------
module ccmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output ccmt_pkg::dp_cmd_type    dp_cmd,
   input  ccmt_pkg::dp_status_type dp_status
);
   import ccmt_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MARK2,
      ST_DIV_FIRST,
      ST_DIV_WALK,
      ST_TR_P,
      ST_TR_S,
      ST_TR_DEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      dp_cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               dp_cmd.latch = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (dp_status.cmd)
               CMD_BEGIN: begin
                  dp_cmd.begin_do = 1'b1;
                  state_in        = ST_IDLE;
               end
               CMD_MOVE: begin
                  state_in = ST_IDLE;
                  if (dp_status.load_pending) begin
                     dp_cmd.move_first = 1'b1;
                  end else begin
                     case (dp_status.mark_kind)
                        MK_SAME: begin
                           dp_cmd.mark     = 1'b1;
                           dp_cmd.set_prev = 1'b1;
                        end
                        MK_TURN: begin
                           dp_cmd.mark          = 1'b1;
                           dp_cmd.mark_prev_dir = 1'b1;
                           state_in             = ST_MARK2;
                        end
                        default: begin
                           dp_cmd.set_prev = 1'b1;
                        end
                     endcase
                  end
               end
               CMD_CLEAR: begin
                  dp_cmd.clear_start = 1'b1;
                  state_in           = ST_CLEAR;
               end
               CMD_STEP: begin
                  case (dp_status.phase)
                     PH_IDLE: begin
                        dp_cmd.trace_init = 1'b1;
                        state_in          = ST_DIV_FIRST;
                     end
                     PH_WALK: begin
                        if (dp_status.geom_dirty) begin
                           dp_cmd.div_start = 1'b1;
                           state_in         = ST_DIV_WALK;
                        end else begin
                           dp_cmd.read_p = 1'b1;
                           state_in      = ST_TR_S;
                        end
                     end
                     default: begin
                        dp_cmd.rsp_closed = 1'b1;
                        rsp_valid_in      = 1'b1;
                        state_in          = ST_IDLE;
                     end
                  endcase
               end
               default: state_in = ST_IDLE;
            endcase
         end
         // second pixel around a corner
         ST_MARK2: begin
            dp_cmd.mark     = 1'b1;
            dp_cmd.set_prev = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_DIV_FIRST: begin
            if (dp_status.div_done) begin
               dp_cmd.rsp_first = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         ST_DIV_WALK: begin
            if (dp_status.div_done) state_in = ST_TR_P;
         end
         ST_TR_P: begin
            dp_cmd.read_p = 1'b1;
            state_in      = ST_TR_S;
         end
         ST_TR_S: begin
            dp_cmd.read_s = 1'b1;
            state_in      = ST_TR_DEC;
         end
         ST_TR_DEC: begin
            dp_cmd.decide = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and result strobe; reset starts the bitmap sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/crack_contour_merge_trace.sv]
// ----------------------------------------------------------------------------
// crack_contour_merge_trace : crack code contour merge and outer trace
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | start, busy            | req_cmd, req_start_index, req_move_code
//   result   | rsp_valid (one cycle)  | rsp_out_move, rsp_move_valid,
//            |                        | rsp_trace_done
//   csr      | csr_we                 | csr_index, csr_wdata
//
// A word is taken when start is high and busy low. A corner move marks two
// pixels, one after the other. A trace step makes two reads of the one-port
// bitmap and then a decision. The first step of a walk waits while the serial
// divider finds row and column, and so does a step after a width write.
// Reset and a clear word sweep the bitmap one entry a cycle, all MAX_PIXELS
// entries (at most 65536), with busy high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module crack_contour_merge_trace #(
   parameter int MAX_PIXELS = ccmt_pkg::MaxPixelsDef
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_cmd,
   input  logic [ccmt_pkg::IdxW-1:0]  req_start_index,
   input  logic [1:0]                 req_move_code,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_out_move,
   output logic                       rsp_move_valid,
   output logic                       rsp_trace_done,
   input  logic                       csr_we,
   input  logic                       csr_index,
   input  logic [ccmt_pkg::GeoW-1:0]  csr_wdata
);
   import ccmt_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ccmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   ccmt_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_cmd),
      .req_start_index (req_start_index),
      .req_move_code   (req_move_code),
      .dp_cmd          (dp_cmd),
      .dp_status       (dp_status),
      .rsp_out_move    (rsp_out_move),
      .rsp_move_valid  (rsp_move_valid),
      .rsp_trace_done  (rsp_trace_done)
   );

   // a result only follows work in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a word in progress");

   // one word gives at most one result
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result words in a row");

   // a closed walk carries no move
   a_closed_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_trace_done) |-> (!rsp_move_valid && (rsp_out_move == 2'(MV_UP))))
      else $error("closed trace with a move attached");

   // reset starts the bitmap sweep
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> busy)
      else $error("bitmap sweep not started after reset");

endmodule
